// ===== design/lpmr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Message ring package
// Shared default size, command and status codes, and the transfer payloads.
// ----------------------------------------------------------------------------
package lpmr_pkg;

    localparam int BUF_BYTES_DEF = 64;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_LEN = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
        logic [6:0] msg_len;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic [1:0] status;
        logic [4:0] message_count;
        logic [6:0] free_bytes;
    } t_out_item;

endpackage
`default_nettype wire

// ===== design/lpmr_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Message ring byte store
// Single write port and single read port; read data is registered.
// ----------------------------------------------------------------------------
module lpmr_ram #(
    parameter int DEPTH  = lpmr_pkg::BUF_BYTES_DEF,
    parameter int ADDR_W = $clog2(lpmr_pkg::BUF_BYTES_DEF)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== design/length_prefixed_message_ring.sv =====
`default_nettype none
// A push of a byte inside an open message writes that byte; the opening byte of
// a message first evicts the oldest messages while space is short, then writes
// the length header and the byte. A pop reads the header, then emits each
// message byte; a reject or an empty pop emits only a status. A new item is
// taken only in idle; results wait in an output register.
// Synchronous reset clears pointers and counts; the store is not cleared.
// ----------------------------------------------------------------------------
// Length-prefixed message ring
// Byte ring holding whole messages behind a two-byte length header, with
// eviction of the oldest messages when a new message does not fit.
// ----------------------------------------------------------------------------
module length_prefixed_message_ring #(
    parameter int BUF_BYTES = lpmr_pkg::BUF_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lpmr_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lpmr_pkg::t_out_item o_out_data
);

    import lpmr_pkg::*;

    localparam int PTR_W = $clog2(BUF_BYTES);
    localparam int CNT_W = $clog2(BUF_BYTES + 1);
    localparam int LEN_W = $clog2(BUF_BYTES - 1);
    localparam int MSG_W = $clog2(BUF_BYTES / 3 + 1);

    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(BUF_BYTES - 1);
    localparam logic [CNT_W-1:0] FULL     = CNT_W'(BUF_BYTES);
    localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(BUF_BYTES - 2);
    localparam logic [7:0]       BUF_W8   = 8'(BUF_BYTES);
    localparam logic [7:0]       MAX_W8   = 8'(BUF_BYTES - 2);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_EV_HI,
        S_EV_LO,
        S_HDR_HI,
        S_HDR_LO,
        S_POP_HI,
        S_POP_LO,
        S_POP_BYTE,
        S_POP_ZERO
    } t_state;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_skip(input logic [PTR_W-1:0] p,
                                                  input logic [LEN_W-1:0] len);
        logic [PTR_W:0] sum;
        sum = {1'b0, p} + (PTR_W+1)'(len) + (PTR_W+1)'(2);
        if (sum >= (PTR_W+1)'(BUF_BYTES)) begin
            sum = sum - (PTR_W+1)'(BUF_BYTES);
        end
        return sum[PTR_W-1:0];
    endfunction

    function automatic t_out_item make_out(input logic [7:0] b, input logic l,
                                           input logic [1:0] st,
                                           input logic [MSG_W-1:0] msgs,
                                           input logic [CNT_W-1:0] space);
        t_out_item o;
        o.out_byte      = b;
        o.last          = l;
        o.status        = st;
        o.message_count = 5'(msgs);
        o.free_bytes    = 7'(space);
        return o;
    endfunction

    t_state            r_state, n_state;
    t_in_item          r_item, n_item;
    logic [PTR_W-1:0]  r_rp, n_rp;
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [MSG_W-1:0]  r_stored, n_stored;
    logic [CNT_W-1:0]  r_space, n_space;
    logic [LEN_W-1:0]  r_expected, n_expected;
    logic [7:0]        r_hi, n_hi;
    logic [PTR_W-1:0]  r_pos, n_pos;
    logic [LEN_W-1:0]  r_remain, n_remain;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic              mem_we;
    logic [PTR_W-1:0]  mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [PTR_W-1:0]  mem_raddr;
    logic [7:0]        mem_rdata;

    logic              can_emit;
    logic [7:0]        need8;
    logic              bad_len;
    logic              short_space;
    logic [LEN_W-1:0]  hdr_len;
    logic [CNT_W:0]    space_sum;
    logic [CNT_W-1:0]  space_rel;
    logic [PTR_W-1:0]  rp_rel;
    logic [PTR_W-1:0]  pos_first;

    lpmr_ram #(
        .DEPTH  (BUF_BYTES),
        .ADDR_W (PTR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign can_emit    = !r_out_valid || i_out_ready;
    assign need8       = {1'b0, r_item.msg_len} + 8'd2;
    assign bad_len     = (r_item.msg_len == 7'd0) || (need8 > BUF_W8);
    assign short_space = (8'(r_space) < need8) && (r_stored != '0);

    assign hdr_len   = (r_hi == 8'h00 && mem_rdata <= MAX_W8) ? LEN_W'(mem_rdata) : MAX_LEN;
    assign space_sum = (CNT_W+1)'(r_space) + (CNT_W+1)'(hdr_len) + (CNT_W+1)'(2);
    assign space_rel = (space_sum > (CNT_W+1)'(BUF_BYTES)) ? FULL : space_sum[CNT_W-1:0];
    assign rp_rel    = ptr_skip(r_rp, hdr_len);
    assign pos_first = ptr_skip(r_rp, '0);

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_rp        = r_rp;
        n_wp        = r_wp;
        n_stored    = r_stored;
        n_space     = r_space;
        n_expected  = r_expected;
        n_hi        = r_hi;
        n_pos       = r_pos;
        n_remain    = r_remain;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = r_wp;
        mem_wdata   = r_item.data_byte;
        mem_re      = 1'b0;
        mem_raddr   = r_rp;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (r_item.cmd == CMD_PUSH) begin
                    if (r_expected != '0) begin
                        if (can_emit) begin
                            mem_we     = 1'b1;
                            n_wp       = ptr_inc(r_wp);
                            n_expected = r_expected - 1'b1;
                            if (r_expected == LEN_W'(1)) begin
                                n_stored = r_stored + 1'b1;
                            end
                            n_out_valid = 1'b1;
                            n_out       = make_out(8'h00, 1'b1, ST_OK, n_stored, r_space);
                            n_state     = S_IDLE;
                        end
                    end else if (bad_len) begin
                        if (can_emit) begin
                            n_out_valid = 1'b1;
                            n_out       = make_out(8'h00, 1'b1, ST_BAD_LEN, r_stored, r_space);
                            n_state     = S_IDLE;
                        end
                    end else if (short_space) begin
                        mem_re  = 1'b1;
                        n_state = S_EV_HI;
                    end else begin
                        n_state = S_HDR_HI;
                    end
                end else begin
                    if (r_stored == '0) begin
                        if (can_emit) begin
                            n_out_valid = 1'b1;
                            n_out       = make_out(8'h00, 1'b1, ST_EMPTY, r_stored, r_space);
                            n_state     = S_IDLE;
                        end
                    end else begin
                        mem_re  = 1'b1;
                        n_state = S_POP_HI;
                    end
                end
            end
            S_EV_HI: begin
                n_hi      = mem_rdata;
                mem_re    = 1'b1;
                mem_raddr = ptr_inc(r_rp);
                n_state   = S_EV_LO;
            end
            S_EV_LO: begin
                n_rp     = rp_rel;
                n_space  = space_rel;
                n_stored = r_stored - 1'b1;
                n_state  = S_DECODE;
            end
            S_HDR_HI: begin
                mem_we    = 1'b1;
                mem_wdata = 8'h00;
                n_wp      = ptr_inc(r_wp);
                n_state   = S_HDR_LO;
            end
            S_HDR_LO: begin
                mem_we     = 1'b1;
                mem_wdata  = {1'b0, r_item.msg_len};
                n_wp       = ptr_inc(r_wp);
                n_space    = (8'(r_space) >= need8) ? CNT_W'(8'(r_space) - need8) : '0;
                n_expected = LEN_W'(r_item.msg_len);
                n_state    = S_DECODE;
            end
            S_POP_HI: begin
                n_hi      = mem_rdata;
                mem_re    = 1'b1;
                mem_raddr = ptr_inc(r_rp);
                n_state   = S_POP_LO;
            end
            S_POP_LO: begin
                n_rp     = rp_rel;
                n_space  = space_rel;
                n_stored = r_stored - 1'b1;
                n_remain = hdr_len;
                if (hdr_len == '0) begin
                    n_state = S_POP_ZERO;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = pos_first;
                    n_pos     = pos_first;
                    n_state   = S_POP_BYTE;
                end
            end
            S_POP_BYTE: begin
                if (can_emit) begin
                    n_out_valid = 1'b1;
                    n_out       = make_out(mem_rdata, r_remain == LEN_W'(1), ST_OK,
                                           r_stored, r_space);
                    if (r_remain == LEN_W'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_pos     = ptr_inc(r_pos);
                        mem_re    = 1'b1;
                        mem_raddr = n_pos;
                        n_remain  = r_remain - 1'b1;
                    end
                end
            end
            S_POP_ZERO: begin
                if (can_emit) begin
                    n_out_valid = 1'b1;
                    n_out       = make_out(8'h00, 1'b1, ST_OK, r_stored, r_space);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_hi     <= n_hi;
        r_pos    <= n_pos;
        r_remain <= n_remain;
        r_out    <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rp        <= '0;
            r_wp        <= '0;
            r_stored    <= '0;
            r_space     <= FULL;
            r_expected  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rp        <= n_rp;
            r_wp        <= n_wp;
            r_stored    <= n_stored;
            r_space     <= n_space;
            r_expected  <= n_expected;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire
